>>> hdl/frma_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// frma_pkg
// Shared types and constants of the frame rate moving average meter.
// ---------------------------------------------------------------------------
package frma_pkg;

    localparam int WINDOW_MAX     = 64;
    localparam int TIME_W         = 32;
    localparam int LEN_W          = 7;
    localparam int LEN_RESET      = 16;
    localparam int RATE_SCALE     = 1000;
    localparam int INST_W         = 10;
    localparam int AVG_W          = 16;
    localparam int DIV_DW         = 17;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_INST_DIV,
        S_AVG_DIV,
        S_DONE
    } t_state;

endpackage : frma_pkg
`default_nettype wire

>>> hdl/frma_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// frma_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module frma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : frma_ram
`default_nettype wire

>>> hdl/frma_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// frma_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module frma_div
    import frma_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_DW-1:0] i_dividend,
    input  wire logic [TIME_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [DIV_DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [TIME_W-1:0] r_dvs;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_sub;
    logic              fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_DW-1]};
        fits    = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule : frma_div
`default_nettype wire

>>> hdl/frame_rate_moving_average.sv
`default_nettype none
// ---------------------------------------------------------------------------
// frame_rate_moving_average
// Frame rate meter: instantaneous rate and moving average over a ring of
// recent frame intervals, both divisions done on one shared serial divider.
// Flow: an accepted item passes an update state, then two divider passes,
// instantaneous rate first and average second (each shifting out 17
// quotient bits and ending in a done strobe), then a state that loads the output register.
// The input stalls while an item is in work, and a stalled output register
// delays the load and the next item.
// Reset: synchronous active low; window length 16, history cleared, last
// timestamp all ones. Ring entries are cleared at once through valid bits.
// ---------------------------------------------------------------------------
module frame_rate_moving_average
    import frma_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [INST_W-1:0]  o_inst_rate,
    output logic                    o_inst_max,
    output logic      [AVG_W-1:0]   o_avg_rate,
    output logic                    o_avg_max,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

    t_state r_state, n_state;

    logic [LEN_W-1:0]      r_window_len;
    logic [TIME_W-1:0]     r_last_time;
    logic [TIME_W-1:0]     r_dt;
    logic [AW-1:0]         r_pos;
    logic [TIME_W-1:0]     r_sum;
    logic [LEN_W-1:0]      r_fill;
    logic [WINDOW_MAX-1:0] r_valid;
    logic [INST_W-1:0]     r_inst_q;
    logic [AVG_W-1:0]      r_avg_q;

    logic                  r_out_valid;
    logic [INST_W-1:0]     r_out_inst;
    logic                  r_out_inst_max;
    logic [AVG_W-1:0]      r_out_avg;
    logic                  r_out_avg_max;

    logic                  in_accept;
    logic                  ram_re;
    logic                  ram_we;
    logic                  div_start;
    logic                  div_sel_avg;
    logic                  inst_cap;
    logic                  out_load;
    logic                  out_free;
    logic                  cfg_wr;

    logic [TIME_W-1:0]     ram_rdata;
    logic [TIME_W-1:0]     old_dt;
    logic [AW:0]           pos_inc;
    logic                  pos_wrap;
    logic [LEN_W-1:0]      len_wr;
    logic                  div_done;
    logic [DIV_DW-1:0]     div_quo;
    logic [DIV_DW-1:0]     div_dividend;
    logic [AVG_W-1:0]      avg_sat;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
    assign prdata   = (paddr[2] == REG_WINDOW_LEN) ?
                      {{(PDATA_W-LEN_W){1'b0}}, r_window_len} : '0;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        len_wr = pwdata[LEN_W-1:0];
        if (len_wr == '0) begin
            len_wr = LEN_W'(1);
        end else if (int'(len_wr) > WINDOW_MAX) begin
            len_wr = LEN_W'(WINDOW_MAX);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPDATE;
            end
            S_UPDATE: n_state = S_INST_DIV;
            S_INST_DIV: begin
                if (div_done) n_state = S_AVG_DIV;
            end
            S_AVG_DIV: begin
                if (div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        in_accept   = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        div_sel_avg = 1'b0;
        inst_cap    = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                in_accept  = i_in_valid;
                ram_re     = i_in_valid;
            end
            S_UPDATE: begin
                ram_we    = 1'b1;
                div_start = 1'b1;
            end
            S_INST_DIV: begin
                inst_cap    = div_done;
                div_start   = div_done;
                div_sel_avg = 1'b1;
            end
            S_AVG_DIV: begin
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign old_dt   = r_valid[r_pos] ? ram_rdata : '0;
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign pos_wrap = (int'(pos_inc) >= int'(r_window_len)) || (int'(pos_inc) >= WINDOW_MAX);

    assign div_dividend = div_sel_avg ? (DIV_DW'(r_fill) * DIV_DW'(RATE_SCALE))
                                      : DIV_DW'(RATE_SCALE);
    assign avg_sat = (|div_quo[DIV_DW-1:AVG_W]) ? {AVG_W{1'b1}} : div_quo[AVG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= LEN_W'(LEN_RST);
            r_last_time  <= '1;
            r_pos        <= '0;
            r_sum        <= '0;
            r_fill       <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_last_time <= i_now_ms;
            end
            if (cfg_wr) begin
                r_window_len <= len_wr;
                r_pos        <= '0;
                r_sum        <= '0;
                r_fill       <= '0;
                r_valid      <= '0;
            end else if (ram_we) begin
                r_sum          <= r_sum + r_dt - old_dt;
                r_valid[r_pos] <= 1'b1;
                r_pos          <= pos_wrap ? '0 : pos_inc[AW-1:0];
                if (r_fill < r_window_len) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dt <= i_now_ms - r_last_time;
        end
        if (inst_cap) begin
            r_inst_q <= div_quo[INST_W-1:0];
        end
        if (r_state == S_AVG_DIV && div_done) begin
            r_avg_q <= avg_sat;
        end
        if (out_load) begin
            r_out_inst_max <= (r_dt == '0);
            r_out_inst     <= (r_dt == '0) ? '0 : r_inst_q;
            r_out_avg_max  <= (r_sum == '0);
            r_out_avg      <= (r_sum == '0) ? '0 : r_avg_q;
        end
    end

    frma_ram #(
        .WIDTH (TIME_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_dt),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    frma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_sel_avg ? r_sum : r_dt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_out_valid = r_out_valid;
    assign o_inst_rate = r_out_inst;
    assign o_inst_max  = r_out_inst_max;
    assign o_avg_rate  = r_out_avg;
    assign o_avg_max   = r_out_avg_max;

endmodule : frame_rate_moving_average
`default_nettype wire
